// File: design/pmb_pkg.sv
// Shared types, constants and codes for the priority message bus.
package pmb_pkg;

    localparam int ID_BITS         = 16;
    localparam int ENERGY_BITS     = 32;
    localparam int PAYLOAD_BITS    = 64;
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam logic [ID_BITS-1:0] BCAST_RESET = 16'hFFFF;
    localparam logic [ID_BITS-1:0] ID_NONE     = '0;

    localparam logic [1:0] OP_EMIT     = 2'd0;
    localparam logic [1:0] OP_LISTEN   = 2'd1;
    localparam logic [1:0] OP_REGISTER = 2'd2;
    localparam logic [1:0] OP_NOP      = 2'd3;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_REPLACED = 2'd1;
    localparam logic [1:0] ST_DROPPED  = 2'd2;
    localparam logic [1:0] ST_NONE     = 2'd3;

    localparam logic [0:0] REG_BCAST = 1'b0;

    typedef struct packed {
        logic [ID_BITS-1:0]      source;
        logic [ID_BITS-1:0]      target;
        logic [ENERGY_BITS-1:0]  energy;
        logic [PAYLOAD_BITS-1:0] payload;
    } msg_t;

endpackage

// File: design/priority_message_bus_with_broadcast.sv
// Top level: bounded priority message queue with broadcast delivery.
// Each beat is handled by one-entry-a-step scans of the listener registry and the queue,
// each step one read of the stores (each with one write port and one registered read port).
// An emit shifts each lower-energy entry down one step; a listen that removes moves later entries up.
// One beat at a time: s_tready is high only when idle, so a new beat waits until the last one is done.
// Reset (rst_n, async low) empties queue and registry; broadcast_id returns to 65535.
module priority_message_bus_with_broadcast #(
    parameter int QueueDepth = pmb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    // in_source, in_target, in_energy, in_payload, listener_id
    input  logic [143:0]  s_tdata,
    // opcode
    input  logic [1:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // out_source, out_target, out_energy, out_payload, emit_status, pending, zero pad
    output logic [135:0]  m_tdata,
    // found
    output logic [0:0]    m_tuser,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [0:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import pmb_pkg::*;

    localparam int IW = $clog2(QueueDepth);

    logic [ID_BITS-1:0] bcast_reg;
    msg_t               msg_in, msg_out, e_wmsg, e_rmsg;
    logic               found;
    logic [1:0]         emit_status;
    logic [4:0]         pending;
    logic               e_we, l_we;
    logic [IW-1:0]      e_waddr, e_raddr, l_waddr, l_raddr;
    logic [QueueDepth-1:0] e_wmarks, e_rmarks;
    logic [ID_BITS-1:0] l_wdata, l_rdata;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_BCAST) ? {16'd0, bcast_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcast_reg <= BCAST_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr == REG_BCAST)
        begin
            bcast_reg <= pwdata[15:0];
        end
    end

    assign msg_in.source  = s_tdata[15:0];
    assign msg_in.target  = s_tdata[31:16];
    assign msg_in.energy  = s_tdata[63:32];
    assign msg_in.payload = s_tdata[127:64];

    assign m_tdata = {1'b0, pending, emit_status, msg_out.payload, msg_out.energy,
                      msg_out.target, msg_out.source};
    assign m_tuser = found;

    pmb_seq #(.QueueDepth(QueueDepth)) u_seq (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .op_in(s_tuser), .msg_in(msg_in), .id_in(s_tdata[143:128]),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .found(found), .msg_out(msg_out), .emit_status(emit_status), .pending(pending),
        .broadcast_id(bcast_reg),
        .e_we(e_we), .e_waddr(e_waddr), .e_wmsg(e_wmsg), .e_wmarks(e_wmarks),
        .e_raddr(e_raddr), .e_rmsg(e_rmsg), .e_rmarks(e_rmarks),
        .l_we(l_we), .l_waddr(l_waddr), .l_wdata(l_wdata),
        .l_raddr(l_raddr), .l_rdata(l_rdata)
    );

    pmb_entry_ram #(.QueueDepth(QueueDepth)) u_entry_ram (
        .clk(clk), .we(e_we), .waddr(e_waddr), .wmsg(e_wmsg), .wmarks(e_wmarks),
        .raddr(e_raddr), .rmsg(e_rmsg), .rmarks(e_rmarks)
    );

    pmb_id_ram #(.QueueDepth(QueueDepth)) u_id_ram (
        .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
        .raddr(l_raddr), .rdata(l_rdata)
    );

endmodule

// File: design/pmb_entry_ram.sv
// Message queue storage: one write port, one registered read port.
module pmb_entry_ram #(
    parameter int QueueDepth = pmb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [$clog2(QueueDepth)-1:0] waddr,
    input  pmb_pkg::msg_t                 wmsg,
    input  logic [QueueDepth-1:0]         wmarks,
    input  logic [$clog2(QueueDepth)-1:0] raddr,
    output pmb_pkg::msg_t                 rmsg,
    output logic [QueueDepth-1:0]         rmarks
);
    import pmb_pkg::*;

    msg_t                  msg_mem   [QueueDepth];
    logic [QueueDepth-1:0] marks_mem [QueueDepth];
    msg_t                  rmsg_reg;
    logic [QueueDepth-1:0] rmarks_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            msg_mem[waddr]   <= wmsg;
            marks_mem[waddr] <= wmarks;
        end
        rmsg_reg   <= msg_mem[raddr];
        rmarks_reg <= marks_mem[raddr];
    end

    assign rmsg   = rmsg_reg;
    assign rmarks = rmarks_reg;

endmodule

// File: design/pmb_id_ram.sv
// Listener id registry storage: one write port, one registered read port.
module pmb_id_ram #(
    parameter int QueueDepth = pmb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [$clog2(QueueDepth)-1:0] waddr,
    input  logic [pmb_pkg::ID_BITS-1:0]   wdata,
    input  logic [$clog2(QueueDepth)-1:0] raddr,
    output logic [pmb_pkg::ID_BITS-1:0]   rdata
);
    import pmb_pkg::*;

    logic [ID_BITS-1:0] id_mem [QueueDepth];
    logic [ID_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            id_mem[waddr] <= wdata;
        end
        rdata_reg <= id_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/pmb_seq.sv
// Operation sequencer: scans, shifts and compares one entry per step.
module pmb_seq #(
    parameter int QueueDepth = pmb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [1:0]                    op_in,
    input  pmb_pkg::msg_t                 msg_in,
    input  logic [pmb_pkg::ID_BITS-1:0]   id_in,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic                          found,
    output pmb_pkg::msg_t                 msg_out,
    output logic [1:0]                    emit_status,
    output logic [4:0]                    pending,
    input  logic [pmb_pkg::ID_BITS-1:0]   broadcast_id,
    output logic                          e_we,
    output logic [$clog2(QueueDepth)-1:0] e_waddr,
    output pmb_pkg::msg_t                 e_wmsg,
    output logic [QueueDepth-1:0]         e_wmarks,
    output logic [$clog2(QueueDepth)-1:0] e_raddr,
    input  pmb_pkg::msg_t                 e_rmsg,
    input  logic [QueueDepth-1:0]         e_rmarks,
    output logic                          l_we,
    output logic [$clog2(QueueDepth)-1:0] l_waddr,
    output logic [pmb_pkg::ID_BITS-1:0]   l_wdata,
    output logic [$clog2(QueueDepth)-1:0] l_raddr,
    input  logic [pmb_pkg::ID_BITS-1:0]   l_rdata
);
    import pmb_pkg::*;

    localparam int IW = $clog2(QueueDepth);
    localparam int CW = $clog2(QueueDepth + 1);
    localparam logic [CW-1:0] FULL = CW'(QueueDepth);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_E_FRD = 4'd1;
    localparam logic [3:0] S_E_FCK = 4'd2;
    localparam logic [3:0] S_E_RD  = 4'd3;
    localparam logic [3:0] S_E_CMP = 4'd4;
    localparam logic [3:0] S_R_RD  = 4'd5;
    localparam logic [3:0] S_R_CMP = 4'd6;
    localparam logic [3:0] S_Q_RD  = 4'd7;
    localparam logic [3:0] S_Q_CMP = 4'd8;
    localparam logic [3:0] S_M_RD  = 4'd9;
    localparam logic [3:0] S_M_WR  = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0]   state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] lcount_reg, lcount_next;
    logic [IW-1:0] slot_reg, slot_next;
    logic          slot_v_reg, slot_v_next;
    logic [1:0]    op_reg, op_next;
    msg_t          in_reg, in_next;
    logic [ID_BITS-1:0] id_reg, id_next;
    logic          found_reg, found_next;
    msg_t          res_reg, res_next;
    logic [1:0]    status_reg, status_next;
    logic          mv_reg, mv_next;
    logic          mf_reg, mf_next;
    msg_t          mmsg_reg, mmsg_next;
    logic [1:0]    mst_reg, mst_next;
    logic [4:0]    mpend_reg, mpend_next;

    logic [CW-1:0]       idx_m1, idx_p1;
    logic [QueueDepth:0] mask_wide;
    logic [QueueDepth-1:0] all_mask, slot_bit, new_marks;

    assign idx_m1    = idx_reg - CW'(1);
    assign idx_p1    = idx_reg + CW'(1);
    assign mask_wide = ({{QueueDepth{1'b0}}, 1'b1} << lcount_reg) - (QueueDepth + 1)'(1);
    assign all_mask  = mask_wide[QueueDepth-1:0];
    assign slot_bit  = {{(QueueDepth-1){1'b0}}, 1'b1} << slot_reg;
    assign new_marks = e_rmarks | slot_bit;

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        lcount_next = lcount_reg;
        slot_next   = slot_reg;
        slot_v_next = slot_v_reg;
        op_next     = op_reg;
        in_next     = in_reg;
        id_next     = id_reg;
        found_next  = found_reg;
        res_next    = res_reg;
        status_next = status_reg;
        mv_next     = mv_reg;
        mf_next     = mf_reg;
        mmsg_next   = mmsg_reg;
        mst_next    = mst_reg;
        mpend_next  = mpend_reg;
        e_we        = 1'b0;
        e_waddr     = idx_reg[IW-1:0];
        e_wmsg      = in_reg;
        e_wmarks    = '0;
        e_raddr     = idx_reg[IW-1:0];
        l_we        = 1'b0;
        l_waddr     = lcount_reg[IW-1:0];
        l_wdata     = id_reg;
        l_raddr     = idx_reg[IW-1:0];

        if (mv_reg && m_tready)
        begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next     = op_in;
                    in_next     = msg_in;
                    id_next     = id_in;
                    found_next  = 1'b0;
                    res_next    = '0;
                    status_next = ST_NONE;
                    slot_v_next = 1'b0;
                    idx_next    = '0;
                    case (op_in)
                        OP_EMIT:
                        begin
                            if (count_reg == FULL)
                            begin
                                state_next = S_E_FRD;
                            end
                            else
                            begin
                                status_next = ST_INSERTED;
                                idx_next    = count_reg;
                                count_next  = count_reg + CW'(1);
                                state_next  = S_E_RD;
                            end
                        end
                        OP_LISTEN:
                            state_next = (count_reg == '0) ? S_DONE : S_R_RD;
                        OP_REGISTER:
                            state_next = S_R_RD;
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end
            S_E_FRD:
            begin
                e_raddr    = IW'(QueueDepth - 1);
                state_next = S_E_FCK;
            end
            S_E_FCK:
            begin
                if (e_rmsg.energy >= in_reg.energy)
                begin
                    status_next = ST_DROPPED;
                    state_next  = S_DONE;
                end
                else
                begin
                    status_next = ST_REPLACED;
                    idx_next    = FULL - CW'(1);
                    state_next  = S_E_RD;
                end
            end
            S_E_RD:
            begin
                if (idx_reg == '0)
                begin
                    e_we       = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    e_raddr    = idx_m1[IW-1:0];
                    state_next = S_E_CMP;
                end
            end
            S_E_CMP:
            begin
                e_we = 1'b1;
                if (e_rmsg.energy < in_reg.energy)
                begin
                    e_wmsg     = e_rmsg;
                    e_wmarks   = e_rmarks;
                    idx_next   = idx_m1;
                    state_next = S_E_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_R_RD:
            begin
                if (idx_reg == lcount_reg)
                begin
                    if (id_reg != ID_NONE && id_reg != broadcast_id && lcount_reg != FULL)
                    begin
                        l_we        = 1'b1;
                        slot_next   = lcount_reg[IW-1:0];
                        slot_v_next = 1'b1;
                        lcount_next = lcount_reg + CW'(1);
                    end
                    idx_next   = '0;
                    state_next = (op_reg == OP_LISTEN) ? S_Q_RD : S_DONE;
                end
                else
                begin
                    state_next = S_R_CMP;
                end
            end
            S_R_CMP:
            begin
                if (l_rdata == id_reg)
                begin
                    slot_next   = idx_reg[IW-1:0];
                    slot_v_next = (id_reg != broadcast_id);
                    idx_next    = '0;
                    state_next  = (op_reg == OP_LISTEN) ? S_Q_RD : S_DONE;
                end
                else
                begin
                    idx_next   = idx_p1;
                    state_next = S_R_RD;
                end
            end
            S_Q_RD:
            begin
                state_next = (idx_reg == count_reg) ? S_DONE : S_Q_CMP;
            end
            S_Q_CMP:
            begin
                if (e_rmsg.target == id_reg)
                begin
                    found_next = 1'b1;
                    res_next   = e_rmsg;
                    state_next = S_M_RD;
                end
                else if (e_rmsg.target == broadcast_id && slot_v_reg &&
                         !e_rmarks[slot_reg])
                begin
                    found_next = 1'b1;
                    res_next   = e_rmsg;
                    if ((new_marks & all_mask) == all_mask)
                    begin
                        state_next = S_M_RD;
                    end
                    else
                    begin
                        e_we       = 1'b1;
                        e_wmsg     = e_rmsg;
                        e_wmarks   = new_marks;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    idx_next   = idx_p1;
                    state_next = S_Q_RD;
                end
            end
            S_M_RD:
            begin
                if (idx_p1 >= count_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    e_raddr    = idx_p1[IW-1:0];
                    state_next = S_M_WR;
                end
            end
            S_M_WR:
            begin
                e_we       = 1'b1;
                e_wmsg     = e_rmsg;
                e_wmarks   = e_rmarks;
                idx_next   = idx_p1;
                state_next = S_M_RD;
            end
            S_DONE:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next    = 1'b1;
                    mf_next    = found_reg;
                    mmsg_next  = res_reg;
                    mst_next   = status_reg;
                    mpend_next = 5'(count_reg);
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            lcount_reg <= '0;
            mv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            lcount_reg <= lcount_next;
            mv_reg     <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        slot_reg   <= slot_next;
        slot_v_reg <= slot_v_next;
        op_reg     <= op_next;
        in_reg     <= in_next;
        id_reg     <= id_next;
        found_reg  <= found_next;
        res_reg    <= res_next;
        status_reg <= status_next;
        mf_reg     <= mf_next;
        mmsg_reg   <= mmsg_next;
        mst_reg    <= mst_next;
        mpend_reg  <= mpend_next;
    end

    assign s_tready    = (state_reg == S_IDLE);
    assign m_tvalid    = mv_reg;
    assign found       = mf_reg;
    assign msg_out     = mmsg_reg;
    assign emit_status = mst_reg;
    assign pending     = mpend_reg;

endmodule

// File: dv/priority_message_bus_with_broadcast_test.sv
// Testbench for the priority message bus: directed and random beats checked against a predictor.
`timescale 1ns / 100ps

module priority_message_bus_with_broadcast_test;
    import pmb_pkg::*;

    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic              found;
        logic [15:0]       src;
        logic [15:0]       tgt;
        logic [31:0]       energy;
        logic [63:0]       payload;
        logic [1:0]        status;
        logic [4:0]        pending;
    } outcome_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [143:0]  s_tdata = '0;
    logic [1:0]    s_tuser = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [135:0]  m_tdata;
    logic [0:0]    m_tuser;
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [0:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;

    priority_message_bus_with_broadcast i_dut (.*);

    always #2 clk = ~clk;

    // predictor state
    logic [15:0] q_src [DEPTH];
    logic [15:0] q_tgt [DEPTH];
    logic [31:0] q_energy [DEPTH];
    logic [63:0] q_payload [DEPTH];
    logic [15:0] q_marks [DEPTH];
    int          q_count;
    logic [15:0] reg_ids [DEPTH];
    int          reg_count;
    logic [15:0] bcast_id;

    outcome_t expected_beats[$];
    int       error_count = 0;
    int       cycle_count = 0;
    bit       no_idle = 1'b0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic int slot_of(input logic [15:0] id);
        if (id == bcast_id) return -1;
        for (int i = 0; i < reg_count; i++)
            if (reg_ids[i] == id) return i;
        return -1;
    endfunction

    function automatic void enrol(input logic [15:0] id);
        if (id == ID_NONE || id == bcast_id || slot_of(id) >= 0 || reg_count >= DEPTH) return;
        reg_ids[reg_count] = id;
        reg_count++;
    endfunction

    function automatic void move_entry(input int dst, input int srci);
        q_src[dst] = q_src[srci];
        q_tgt[dst] = q_tgt[srci];
        q_energy[dst] = q_energy[srci];
        q_payload[dst] = q_payload[srci];
        q_marks[dst] = q_marks[srci];
    endfunction

    function automatic void drop_entry(input int k);
        for (int i = k; i + 1 < q_count; i++) move_entry(i, i + 1);
        q_count--;
        q_marks[q_count] = '0;
    endfunction

    function automatic outcome_t bus_predict(input logic [1:0] op, input logic [15:0] src,
                                             input logic [15:0] tgt, input logic [31:0] en,
                                             input logic [63:0] pl, input logic [15:0] sid);
        outcome_t r;
        int k;
        int slot;
        logic [15:0] all;
        r = '0;
        r.status = ST_NONE;
        if (op == OP_EMIT)
        begin
            if (q_count >= DEPTH)
            begin
                k = DEPTH - 1;
                if (q_energy[k] >= en) r.status = ST_DROPPED;
                else
                begin
                    r.status = ST_REPLACED;
                    while (k > 0 && q_energy[k-1] < en)
                    begin
                        move_entry(k, k - 1);
                        k--;
                    end
                    q_src[k] = src; q_tgt[k] = tgt; q_energy[k] = en;
                    q_payload[k] = pl; q_marks[k] = '0;
                end
            end
            else
            begin
                r.status = ST_INSERTED;
                k = 0;
                while (k < q_count && q_energy[k] >= en) k++;
                for (int i = q_count; i > k; i--) move_entry(i, i - 1);
                q_src[k] = src; q_tgt[k] = tgt; q_energy[k] = en;
                q_payload[k] = pl; q_marks[k] = '0;
                q_count++;
            end
        end
        else if (op == OP_LISTEN)
        begin
            if (q_count > 0)
            begin
                enrol(sid);
                slot = slot_of(sid);
                for (int i = 0; i < q_count; i++)
                begin
                    if (q_tgt[i] == sid)
                    begin
                        r.found = 1'b1;
                    end
                    else if (q_tgt[i] == bcast_id && slot >= 0 && !q_marks[i][slot])
                    begin
                        r.found = 1'b1;
                        q_marks[i][slot] = 1'b1;
                    end
                    if (r.found)
                    begin
                        r.src = q_src[i]; r.tgt = q_tgt[i];
                        r.energy = q_energy[i]; r.payload = q_payload[i];
                        all = (reg_count >= 16) ? 16'hFFFF : 16'((1 << reg_count) - 1);
                        if (q_tgt[i] == sid || (q_marks[i] & all) == all) drop_entry(i);
                        break;
                    end
                end
            end
        end
        else if (op == OP_REGISTER)
        begin
            enrol(sid);
        end
        r.pending = 5'(q_count);
        return r;
    endfunction

    task automatic send_beat(input logic [1:0] op, input logic [15:0] src, input logic [15:0] tgt,
                             input logic [31:0] en, input logic [63:0] pl, input logic [15:0] sid);
        if (!no_idle && $urandom_range(99) < 36)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while (!no_idle && $urandom_range(99) < 36) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {sid, pl, en, tgt, src};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        expected_beats.push_back(bus_predict(op, src, tgt, en, pl, sid));
    endtask

    // single-beat wrappers
    task automatic emit(input logic [15:0] src, input logic [15:0] tgt, input logic [31:0] en);
        send_beat(OP_EMIT, src, tgt, en, {$urandom, $urandom}, 16'($urandom));
    endtask

    task automatic listen(input logic [15:0] sid);
        send_beat(OP_LISTEN, 16'($urandom), 16'($urandom), $urandom, {$urandom, $urandom}, sid);
    endtask

    task automatic drain_and_wait();
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_bcast(input logic [15:0] id);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_BCAST; pwdata <= 32'(id);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        bcast_id = id;
    endtask

    task automatic test_extremes();
        send_beat(OP_LISTEN, 16'hFFFF, 16'hFFFF, '1, '1, 16'h0005);
        send_beat(OP_NOP, '1, '1, '1, '1, '1);
        send_beat(OP_REGISTER, '0, '0, '0, '0, ID_NONE);
        send_beat(OP_REGISTER, '0, '0, '0, '0, 16'hFFFF);
        send_beat(OP_REGISTER, '0, '0, '0, '0, 16'h0003);
        send_beat(OP_REGISTER, '0, '0, '0, '0, 16'h0003);
        send_beat(OP_EMIT, 16'hFFFF, 16'h0003, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, '1);
        send_beat(OP_EMIT, '0, 16'hFFFF, '0, '0, '0);
        send_beat(OP_EMIT, 16'h0001, 16'hFFFF, '0, 64'h1234, '0);
        listen(16'h0003);
        listen(16'h0007);
        listen(16'h0003);
        listen(16'h0007);
        listen(16'hFFFF);
        listen(ID_NONE);
        listen(16'hFFFF);
    endtask

    task automatic test_full_queue();
        for (int i = 0; i < 18; i++) emit(16'(i), 16'h0040, 32'(i % 5 + 10));
        emit(16'h00AA, 16'h0041, 32'd10);
        emit(16'h00AB, 16'h0041, 32'd11);
        emit(16'h00AC, 16'h0041, 32'd14);
        for (int i = 0; i < 20; i++) listen(16'h0040 + 16'(i & 1));
        drain_and_wait();
    endtask

    task automatic test_registry_full();
        for (int i = 1; i <= 20; i++) send_beat(OP_REGISTER, '0, '0, '0, '0, 16'(100 + i));
        emit(16'h0001, bcast_id, 32'd50);
        emit(16'h0002, 16'd120, 32'd40);
        for (int i = 1; i <= 20; i++) listen(16'(100 + i));
        drain_and_wait();
    endtask

    function automatic logic [15:0] pick_id();
        int c;
        c = $urandom_range(99);
        if (c < 10) return bcast_id;
        if (c < 14) return ID_NONE;
        if (c < 20) return 16'($urandom);
        return 16'($urandom_range(1, 6));
    endfunction

    task automatic test_random(input int n);
        int c;
        for (int i = 0; i < n; i++)
        begin
            no_idle = (i >= n / 2 && i < n / 2 + 100);
            c = $urandom_range(99);
            if (c < 45)
                send_beat(OP_EMIT, 16'($urandom), pick_id(),
                          ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(8)),
                          {$urandom, $urandom}, 16'($urandom));
            else if (c < 88)
                send_beat(OP_LISTEN, 16'($urandom), 16'($urandom), $urandom,
                          {$urandom, $urandom}, pick_id());
            else if (c < 96)
                send_beat(OP_REGISTER, 16'($urandom), 16'($urandom), $urandom,
                          {$urandom, $urandom}, pick_id());
            else
                send_beat(OP_NOP, 16'($urandom), 16'($urandom), $urandom,
                          {$urandom, $urandom}, 16'($urandom));
        end
        no_idle = 1'b0;
        drain_and_wait();
    endtask

    always @(posedge clk)
    begin
        m_tready <= no_idle || ($urandom_range(99) >= 36);
    end

    always @(posedge clk)
    begin
        outcome_t want;
        outcome_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tuser[0], m_tdata[15:0], m_tdata[31:16], m_tdata[63:32], m_tdata[127:64],
                   m_tdata[129:128], m_tdata[134:130]};
            if (expected_beats.size() == 0) report("unexpected beat", '0, '0);
            else
            begin
                want = expected_beats.pop_front();
                if (got.found != want.found) report("found", got.found, want.found);
                if (got.src != want.src) report("source", got.src, want.src);
                if (got.tgt != want.tgt) report("target", got.tgt, want.tgt);
                if (got.energy != want.energy) report("energy", got.energy, want.energy);
                if (got.payload != want.payload) report("payload", got.payload, want.payload);
                if (got.status != want.status) report("status", got.status, want.status);
                if (got.pending != want.pending) report("pending", got.pending, want.pending);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("priority_message_bus_with_broadcast_test: errors");
            $finish;
        end
    end

    initial
    begin
        q_count = 0;
        reg_count = 0;
        bcast_id = BCAST_RESET;
        for (int i = 0; i < DEPTH; i++)
        begin
            q_marks[i] = '0;
            reg_ids[i] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_full_queue();
        drain_and_wait();
        write_bcast(16'h0002);
        test_registry_full();
        test_random(450);
        write_bcast(16'h0000);
        test_random(450);
        write_bcast(16'hFFFF);
        test_random(450);
        drain_and_wait();
        if (error_count == 0)
            $display("priority_message_bus_with_broadcast_test: clean");
        else
            $display("priority_message_bus_with_broadcast_test: errors");
        $finish;
    end

endmodule

// File: priority_message_bus_with_broadcast.f
design/pmb_pkg.sv
design/pmb_entry_ram.sv
design/pmb_id_ram.sv
design/pmb_seq.sv
design/priority_message_bus_with_broadcast.sv
dv/priority_message_bus_with_broadcast_test.sv
